FILE: rtl/letterbox_nearest_upscaler_defines.svh
// Assertion macros used by the letterbox upscaler checker
`ifndef LETTERBOX_NEAREST_UPSCALER_DEFINES_SVH
`define LETTERBOX_NEAREST_UPSCALER_DEFINES_SVH

// Check a consequence in the cycle after the antecedent, outside reset
`define LNU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Check what the cycle after a reset edge shows
`define LNU_ASSERT_RESET(label, cons, msg) \
    label: assert property (@(posedge i_clk) !i_rst_n |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/lnu_pkg.sv
// Shared types, constants and widths of the letterbox nearest-neighbor upscaler
package lnu_pkg;

    // Block constants
    localparam int MAX_DIM         = 4096;
    localparam int MAX_SCALE       = 8;
    localparam int SCALE_FRAC_BITS = 16;

    // Field widths
    localparam int REG_W      = 13;
    localparam int COORD_W    = 12;
    localparam int COLOR_W    = 16;
    localparam int COLOR_FRAC = 4;
    localparam int CHAN_W     = 8;
    localparam int WORD_W     = 3 * CHAN_W;
    localparam int COLOR_MAX_Q = 255 * (1 << COLOR_FRAC);

    // Derived datapath widths
    localparam int SCALE_W   = SCALE_FRAC_BITS + $clog2(MAX_SCALE) + 1;
    localparam int DIV_NUM_W = REG_W + SCALE_FRAC_BITS;
    localparam int ACC_W     = SCALE_W + REG_W;
    localparam int QUO_W     = ACC_W - SCALE_FRAC_BITS;
    localparam int SPAN_W    = QUO_W + 1;
    localparam int PROD_W    = REG_W + SCALE_W + 1;
    localparam int ROUND_HALF = 1 << (SCALE_FRAC_BITS - 1);
    localparam logic [DIV_NUM_W-1:0] SCALE_CAP =
        DIV_NUM_W'(MAX_SCALE) << SCALE_FRAC_BITS;

    localparam int DEFAULT_QUEUE_DEPTH = 4;

    // Register reset values
    localparam logic [REG_W-1:0] RST_SRC_WIDTH  = REG_W'(320);
    localparam logic [REG_W-1:0] RST_SRC_HEIGHT = REG_W'(240);
    localparam logic [REG_W-1:0] RST_DST_WIDTH  = REG_W'(640);
    localparam logic [REG_W-1:0] RST_DST_HEIGHT = REG_W'(480);

    // Register indexes
    typedef enum logic [1:0] {
        CFG_SRC_WIDTH  = 2'd0,
        CFG_SRC_HEIGHT = 2'd1,
        CFG_DST_WIDTH  = 2'd2,
        CFG_DST_HEIGHT = 2'd3
    } t_cfg_idx;

    // Input transaction
    typedef struct packed {
        logic signed [COLOR_W-1:0] red_in;
        logic signed [COLOR_W-1:0] green_in;
        logic signed [COLOR_W-1:0] blue_in;
    } t_in_item;

    // Output transaction
    typedef struct packed {
        logic [COORD_W-1:0] dst_x;
        logic [COORD_W-1:0] dst_y;
        logic [WORD_W-1:0]  pixel_word;
        logic               last_write;
    } t_out_item;

    // One destination rectangle to paint, end coordinates exclusive
    typedef struct packed {
        logic [COORD_W-1:0] x_lo;
        logic [REG_W-1:0]   x_end;
        logic [COORD_W-1:0] y_lo;
        logic [REG_W-1:0]   y_end;
        logic [WORD_W-1:0]  pixel_word;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [REG_W-1:0]     den;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quo;
    } t_div_rsp;

    typedef enum logic [3:0] {
        FS_DIVX_GO,
        FS_DIVX_WAIT,
        FS_DIVY_GO,
        FS_DIVY_WAIT,
        FS_SCALE,
        FS_MULX,
        FS_OFFX,
        FS_MULY,
        FS_OFFY,
        FS_SPAN,
        FS_READY,
        FS_ADV
    } t_front_state;

endpackage

FILE: rtl/lnu_divider.sv
// Restoring divider, one quotient bit per cycle, for the frame scale
module lnu_divider (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  lnu_pkg::t_div_req i_req,
    output lnu_pkg::t_div_rsp o_rsp
);
    import lnu_pkg::*;

    localparam int CNT_W = $clog2(DIV_NUM_W + 1);

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_W-1:0]     r_cnt;
    logic [REG_W-1:0]     r_rem;
    logic [REG_W-1:0]     r_den;
    logic [DIV_NUM_W-1:0] r_quo;

    logic [REG_W:0]       trial;
    logic                 fits;
    logic [REG_W-1:0]     n_rem;

    // Trial subtract of the divisor from the shifted remainder
    always_comb begin
        trial = {r_rem, r_quo[DIV_NUM_W-1]};
        fits  = trial >= {1'b0, r_den};
        if (fits) begin
            n_rem = REG_W'(trial - {1'b0, r_den});
        end else begin
            n_rem = REG_W'(trial);
        end
    end

    // Sequence control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            // pulse done on the last quotient step
            r_done <= !i_req.start && r_busy && (r_cnt == CNT_W'(1));
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Shift the numerator out and the quotient in
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_den <= i_req.den;
            r_quo <= i_req.num;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[DIV_NUM_W-2:0], fits};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule

FILE: rtl/lnu_queue.sv
// Command queue between the span front end and the write back end
module lnu_queue #(
    parameter int DEPTH = lnu_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  lnu_pkg::t_cmd      i_push_cmd,
    input  logic               i_pop,
    output lnu_pkg::t_cmd      o_pop_cmd,
    output lnu_pkg::t_q_status o_status
);
    import lnu_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_cmd;
        end
    end

    assign o_pop_cmd      = r_mem[r_rd];
    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);

endmodule

FILE: rtl/lnu_front.sv
// Front end: registers, frame setup, pixel packing and span computation
module lnu_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  lnu_pkg::t_cfg_idx           i_cfg_index,
    input  logic [lnu_pkg::REG_W-1:0]   i_cfg_data,
    input  logic                        i_in_valid,
    input  lnu_pkg::t_in_item           i_in_data,
    output logic                        o_in_stall,
    output logic                        o_push,
    output lnu_pkg::t_cmd               o_push_cmd,
    input  lnu_pkg::t_q_status          i_q_status,
    output lnu_pkg::t_div_req           o_div_req,
    input  lnu_pkg::t_div_rsp           i_div_rsp
);
    import lnu_pkg::*;

    // Map a register value to the range 1..MAX_DIM
    function automatic logic [REG_W-1:0] clamp_dim(input logic [REG_W-1:0] v);
        logic [REG_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = REG_W'(1);
        end else if (32'(v) > MAX_DIM) begin
            r = REG_W'(MAX_DIM);
        end
        return r;
    endfunction

    // Clamp a Q12.4 component to 0..255 and drop the fraction
    function automatic logic [CHAN_W-1:0] color8(input logic signed [COLOR_W-1:0] c);
        logic [CHAN_W-1:0] r;
        if (c[COLOR_W-1]) begin
            r = '0;
        end else if ($unsigned(c) > COLOR_W'(COLOR_MAX_Q)) begin
            r = '1;
        end else begin
            r = c[COLOR_FRAC+CHAN_W-1:COLOR_FRAC];
        end
        return r;
    endfunction

    // Round the scaled size, clip it to the destination and center it
    function automatic logic [COORD_W-1:0] fit_offset(input logic [PROD_W-1:0] prod,
                                                      input logic [REG_W-1:0] d);
        logic [PROD_W-1:0] rnd;
        logic [PROD_W-1:0] outv;
        logic [PROD_W-1:0] dd;
        rnd  = prod + PROD_W'(ROUND_HALF);
        outv = rnd >> SCALE_FRAC_BITS;
        dd   = PROD_W'(d);
        if (outv > dd) begin
            outv = dd;
        end
        return COORD_W'((dd - outv) >> 1);
    endfunction

    t_front_state r_state;
    t_front_state n_state;

    logic [REG_W-1:0]     r_src_w;
    logic [REG_W-1:0]     r_src_h;
    logic [REG_W-1:0]     r_dst_w;
    logic [REG_W-1:0]     r_dst_h;
    logic [DIV_NUM_W-1:0] r_sx;
    logic [DIV_NUM_W-1:0] r_sy;
    logic [SCALE_W-1:0]   r_scale;
    logic [PROD_W-1:0]    r_prod;
    logic [COORD_W-1:0]   r_off_c;
    logic [COORD_W-1:0]   r_off_r;
    logic [COORD_W-1:0]   r_col;
    logic [COORD_W-1:0]   r_row;
    logic [ACC_W-1:0]     r_col_acc;
    logic [ACC_W-1:0]     r_col_nxt;
    logic [ACC_W-1:0]     r_row_acc;
    logic [ACC_W-1:0]     r_row_nxt;
    logic [SPAN_W-1:0]    r_x_lo;
    logic [SPAN_W-1:0]    r_x_hi;
    logic [SPAN_W-1:0]    r_y_lo;
    logic [SPAN_W-1:0]    r_y_hi;

    logic [REG_W-1:0]     sw;
    logic [REG_W-1:0]     sh;
    logic [REG_W-1:0]     dw;
    logic [REG_W-1:0]     dh;
    logic [DIV_NUM_W-1:0] s_min;
    logic [DIV_NUM_W-1:0] s_cap;
    logic [REG_W-1:0]     mul_dim;
    logic [PROD_W-1:0]    mul_prod;
    logic [QUO_W-1:0]     col_lo_q;
    logic [QUO_W-1:0]     col_hi_q;
    logic [QUO_W-1:0]     row_lo_q;
    logic [QUO_W-1:0]     row_hi_q;
    logic [SPAN_W-1:0]    x_lo_n;
    logic [SPAN_W-1:0]    x_hi_n;
    logic [SPAN_W-1:0]    y_lo_n;
    logic [SPAN_W-1:0]    y_hi_n;
    logic                 span_empty;
    logic                 col_last;
    logic                 row_last;

    assign sw = clamp_dim(r_src_w);
    assign sh = clamp_dim(r_src_h);
    assign dw = clamp_dim(r_dst_w);
    assign dh = clamp_dim(r_dst_h);

    // Scale: smaller axis ratio, capped
    always_comb begin
        s_min = (r_sx < r_sy) ? r_sx : r_sy;
        s_cap = (s_min > SCALE_CAP) ? SCALE_CAP : s_min;
    end

    // One multiplier for both output sizes
    assign mul_dim  = (r_state == FS_MULY) ? sh : sw;
    assign mul_prod = PROD_W'(mul_dim) * PROD_W'(r_scale);

    // Span start and end from the running products position * scale
    always_comb begin
        col_lo_q = r_col_acc[ACC_W-1:SCALE_FRAC_BITS];
        col_hi_q = r_col_nxt[ACC_W-1:SCALE_FRAC_BITS];
        row_lo_q = r_row_acc[ACC_W-1:SCALE_FRAC_BITS];
        row_hi_q = r_row_nxt[ACC_W-1:SCALE_FRAC_BITS];
        x_lo_n = SPAN_W'(r_off_c) + SPAN_W'(col_lo_q);
        y_lo_n = SPAN_W'(r_off_r) + SPAN_W'(row_lo_q);
        // widen a span of zero to one pixel
        x_hi_n = SPAN_W'(r_off_c) + ((col_hi_q == col_lo_q) ?
                 SPAN_W'(col_lo_q) + SPAN_W'(1) : SPAN_W'(col_hi_q));
        y_hi_n = SPAN_W'(r_off_r) + ((row_hi_q == row_lo_q) ?
                 SPAN_W'(row_lo_q) + SPAN_W'(1) : SPAN_W'(row_hi_q));
    end

    // Clip the span to the destination and pack the color
    always_comb begin
        span_empty = (r_x_lo >= SPAN_W'(dw)) || (r_y_lo >= SPAN_W'(dh));
        o_push_cmd.x_lo  = COORD_W'(r_x_lo);
        o_push_cmd.y_lo  = COORD_W'(r_y_lo);
        o_push_cmd.x_end = (r_x_hi > SPAN_W'(dw)) ? dw : REG_W'(r_x_hi);
        o_push_cmd.y_end = (r_y_hi > SPAN_W'(dh)) ? dh : REG_W'(r_y_hi);
        o_push_cmd.pixel_word = {color8(i_in_data.red_in),
                                 color8(i_in_data.green_in),
                                 color8(i_in_data.blue_in)};
    end

    assign col_last = ({1'b0, r_col} + REG_W'(1)) == sw;
    assign row_last = ({1'b0, r_row} + REG_W'(1)) == sh;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FS_DIVX_GO;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and handshake
    always_comb begin
        n_state         = r_state;
        o_in_stall      = 1'b1;
        o_push          = 1'b0;
        o_div_req.start = 1'b0;
        o_div_req.num   = {dw, {SCALE_FRAC_BITS{1'b0}}};
        o_div_req.den   = sw;
        unique case (r_state)
            FS_DIVX_GO: begin
                o_div_req.start = 1'b1;
                n_state = FS_DIVX_WAIT;
            end
            FS_DIVX_WAIT: begin
                if (i_div_rsp.done) begin
                    n_state = FS_DIVY_GO;
                end
            end
            FS_DIVY_GO: begin
                o_div_req.start = 1'b1;
                o_div_req.num   = {dh, {SCALE_FRAC_BITS{1'b0}}};
                o_div_req.den   = sh;
                n_state = FS_DIVY_WAIT;
            end
            FS_DIVY_WAIT: begin
                if (i_div_rsp.done) begin
                    n_state = FS_SCALE;
                end
            end
            FS_SCALE: n_state = FS_MULX;
            FS_MULX:  n_state = FS_OFFX;
            FS_OFFX:  n_state = FS_MULY;
            FS_MULY:  n_state = FS_OFFY;
            FS_OFFY:  n_state = FS_SPAN;
            FS_SPAN:  n_state = FS_READY;
            FS_READY: begin
                o_in_stall = i_q_status.full;
                if (i_in_valid && !i_q_status.full) begin
                    // drop a pixel that lands fully outside the destination
                    o_push  = !span_empty;
                    n_state = FS_ADV;
                end
            end
            FS_ADV: begin
                n_state = (col_last && row_last) ? FS_DIVX_GO : FS_SPAN;
            end
            default: n_state = FS_DIVX_GO;
        endcase
        // restart the frame on any register write
        if (i_cfg_we) begin
            n_state = FS_DIVX_GO;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w <= RST_SRC_WIDTH;
            r_src_h <= RST_SRC_HEIGHT;
            r_dst_w <= RST_DST_WIDTH;
            r_dst_h <= RST_DST_HEIGHT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SRC_WIDTH:  r_src_w <= i_cfg_data;
                CFG_SRC_HEIGHT: r_src_h <= i_cfg_data;
                CFG_DST_WIDTH:  r_dst_w <= i_cfg_data;
                CFG_DST_HEIGHT: r_dst_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Raster position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (r_state == FS_OFFY) begin
            r_col <= '0;
            r_row <= '0;
        end else if (r_state == FS_ADV) begin
            if (col_last) begin
                r_col <= '0;
                r_row <= row_last ? '0 : r_row + COORD_W'(1);
            end else begin
                r_col <= r_col + COORD_W'(1);
            end
        end
    end

    // Frame setup and span datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            FS_DIVX_WAIT: begin
                if (i_div_rsp.done) begin
                    r_sx <= i_div_rsp.quo;
                end
            end
            FS_DIVY_WAIT: begin
                if (i_div_rsp.done) begin
                    r_sy <= i_div_rsp.quo;
                end
            end
            FS_SCALE: r_scale <= SCALE_W'(s_cap);
            FS_MULX:  r_prod  <= mul_prod;
            FS_OFFX:  r_off_c <= fit_offset(r_prod, dw);
            FS_MULY:  r_prod  <= mul_prod;
            FS_OFFY: begin
                r_off_r   <= fit_offset(r_prod, dh);
                r_col_acc <= '0;
                r_col_nxt <= ACC_W'(r_scale);
                r_row_acc <= '0;
                r_row_nxt <= ACC_W'(r_scale);
            end
            FS_SPAN: begin
                r_x_lo <= x_lo_n;
                r_x_hi <= x_hi_n;
                r_y_lo <= y_lo_n;
                r_y_hi <= y_hi_n;
            end
            FS_ADV: begin
                // advance the running products by one scale step
                if (col_last) begin
                    r_col_acc <= '0;
                    r_col_nxt <= ACC_W'(r_scale);
                    r_row_acc <= r_row_nxt;
                    r_row_nxt <= r_row_nxt + ACC_W'(r_scale);
                end else begin
                    r_col_acc <= r_col_nxt;
                    r_col_nxt <= r_col_nxt + ACC_W'(r_scale);
                end
            end
            default: ;
        endcase
    end

endmodule

FILE: rtl/lnu_back.sv
// Back end: walks each queued rectangle and issues one write per pixel
module lnu_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lnu_pkg::t_q_status i_q_status,
    input  lnu_pkg::t_cmd      i_pop_cmd,
    output logic               o_pop,
    output logic               o_out_valid,
    output lnu_pkg::t_out_item o_out_data,
    input  logic               i_out_stall
);
    import lnu_pkg::*;

    logic               r_busy;
    logic               r_out_valid;
    t_out_item          r_out_data;
    t_cmd               r_cmd;
    logic [COORD_W-1:0] r_x;
    logic [COORD_W-1:0] r_y;

    logic slot_free;
    logic emit;
    logic x_last;
    logic y_last;
    logic item_done;
    logic load;

    // Emit when the output register is free or being taken
    always_comb begin
        slot_free = !r_out_valid || !i_out_stall;
        emit      = r_busy && slot_free;
        x_last    = ({1'b0, r_x} + REG_W'(1)) == r_cmd.x_end;
        y_last    = ({1'b0, r_y} + REG_W'(1)) == r_cmd.y_end;
        item_done = x_last && y_last;
        // take the next rectangle as the current one finishes
        load      = !i_q_status.empty && (!r_busy || (emit && item_done));
    end

    assign o_pop = load;

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (load) begin
                r_busy <= 1'b1;
            end else if (emit && item_done) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Walk the rectangle in row-major order and hold the output transaction
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_data.dst_x      <= r_x;
            r_out_data.dst_y      <= r_y;
            r_out_data.pixel_word <= r_cmd.pixel_word;
            r_out_data.last_write <= item_done;
        end
        if (load) begin
            r_cmd <= i_pop_cmd;
            r_x   <= i_pop_cmd.x_lo;
            r_y   <= i_pop_cmd.y_lo;
        end else if (emit) begin
            if (x_last) begin
                r_x <= r_cmd.x_lo;
                r_y <= r_y + COORD_W'(1);
            end else begin
                r_x <= r_x + COORD_W'(1);
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

FILE: rtl/letterbox_nearest_upscaler.sv
// Top level of the letterbox nearest-neighbor upscaler
// Source pixels are taken in raster order and each is painted as a rectangle of
// destination writes, one write per cycle from the back end while the output
// is not stalled, row-major, with last_write on the final write of the pixel.
// The front end takes each source pixel through three steps (accept, raster
// advance, span update); the command queue lets the two ends run apart while
// the output is stalled. Frame setup runs after reset, after every register
// write and after the last pixel of each frame: two 29-step divisions on the
// shared divider plus the size and offset steps, during which no pixel is taken.
// Write registers only while idle.
module letterbox_nearest_upscaler #(
    parameter int QUEUE_DEPTH = lnu_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  lnu_pkg::t_cfg_idx         i_cfg_index,
    input  logic [lnu_pkg::REG_W-1:0] i_cfg_data,
    input  logic                      i_in_valid,
    input  lnu_pkg::t_in_item         i_in_data,
    output logic                      o_in_stall,
    output logic                      o_out_valid,
    output lnu_pkg::t_out_item        o_out_data,
    input  logic                      i_out_stall
);
    import lnu_pkg::*;

    logic      push;
    t_cmd      push_cmd;
    logic      pop;
    t_cmd      pop_cmd;
    t_q_status q_status;
    t_div_req  div_req;
    t_div_rsp  div_rsp;

    // Shared divider for the frame scale
    lnu_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Span front end
    lnu_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_push      (push),
        .o_push_cmd  (push_cmd),
        .i_q_status  (q_status),
        .o_div_req   (div_req),
        .i_div_rsp   (div_rsp)
    );

    // Rectangle queue
    lnu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_cmd (push_cmd),
        .i_pop      (pop),
        .o_pop_cmd  (pop_cmd),
        .o_status   (q_status)
    );

    // Write back end
    lnu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_status  (q_status),
        .i_pop_cmd   (pop_cmd),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule

FILE: rtl/lnu_checker.sv
// Port-level checker for the letterbox upscaler and its bind
`include "letterbox_nearest_upscaler_defines.svh"

module lnu_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input lnu_pkg::t_out_item o_out_data,
    input logic               i_out_stall
);
    import lnu_pkg::*;

    // Hold a stalled output transaction
    `LNU_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data), "stalled output changed")

    // Keep writes of one pixel back to back with the same color
    `LNU_ASSERT_NEXT(a_pixel_burst, o_out_valid && !i_out_stall && !o_out_data.last_write, o_out_valid && o_out_data.pixel_word == $past(o_out_data.pixel_word), "pixel burst broken")

    // Step one column right or move to the next row within a pixel
    `LNU_ASSERT_NEXT(a_raster_step, o_out_valid && !i_out_stall && !o_out_data.last_write, (o_out_data.dst_x == $past(o_out_data.dst_x) + 12'd1 && o_out_data.dst_y == $past(o_out_data.dst_y)) || (o_out_data.dst_y == $past(o_out_data.dst_y) + 12'd1), "write order broken")

    // Stall the input for the raster advance after each transaction
    `LNU_ASSERT_NEXT(a_in_gap, i_in_valid && !o_in_stall, o_in_stall, "input taken back to back")

    // Come out of reset with no write pending and frame setup running
    `LNU_ASSERT_RESET(a_reset_state, !o_out_valid && o_in_stall, "bad state after reset")

endmodule

bind letterbox_nearest_upscaler lnu_checker u_lnu_checker (.*);

FILE: test/letterbox_nearest_upscaler_test.sv
// Self-checking testbench of the letterbox nearest-neighbor upscaler
module letterbox_nearest_upscaler_test;
    timeunit 1ns;
    timeprecision 1ps;

    import lnu_pkg::*;

    localparam int SETTLE_CYCLES = 160;
    localparam int HOLD_CYCLES   = 400;
    localparam int MAX_WRITES    = 64;
    localparam int REPORT_LIMIT  = 40;
    localparam int TIMEOUT_NS    = 24_000_000;

    // One directed pixel, with the packed color typed in where it is obvious
    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        bit                 typed;
        logic [WORD_W-1:0]  word;
    } t_swatch;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    t_cfg_idx           i_cfg_index;
    logic [REG_W-1:0]   i_cfg_data;
    logic               i_in_valid;
    t_in_item           i_in_data;
    logic               o_in_stall;
    logic               o_out_valid;
    t_out_item          o_out_data;
    logic               i_out_stall;

    // Geometry mirror and frame state of the predictor
    logic [REG_W-1:0]   geom_regs [4];
    logic [SCALE_W-1:0] frame_scale;
    bit                 frame_valid;
    logic [COORD_W-1:0] pad_x;
    logic [COORD_W-1:0] pad_y;
    logic [REG_W-1:0]   raster_col;
    logic [REG_W-1:0]   raster_row;
    t_out_item          writes_due [$];

    // Run bookkeeping shared by the sender and the receiver
    bit                 calm;
    bit                 hold_window;
    int                 mismatches;
    int                 writes_checked;
    int                 pixels_sent;
    int                 frames_started;
    int                 settings_loaded;

    letterbox_nearest_upscaler u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("%0t: timeout, %0d writes still pending", $time, writes_due.size());
        $display("letterbox_nearest_upscaler_test: errors");
        $finish;
    end

    // Dimension as the block uses it: zero acts as one, cap at MAX_DIM
    function automatic logic [REG_W-1:0] usable_dim(input logic [REG_W-1:0] v);
        if (v == '0) return REG_W'(1);
        if (v > REG_W'(MAX_DIM)) return REG_W'(MAX_DIM);
        return v;
    endfunction

    // Clamp a Q12.4 component to 0..255 and drop the fraction
    function automatic logic [CHAN_W-1:0] clamp_channel(input logic signed [COLOR_W-1:0] q);
        if (q < 0) return '0;
        if (q > COLOR_MAX_Q) return '1;
        return CHAN_W'(q >> COLOR_FRAC);
    endfunction

    function automatic logic [WORD_W-1:0] pack_color(input t_in_item px);
        return {clamp_channel(px.red_in), clamp_channel(px.green_in),
                clamp_channel(px.blue_in)};
    endfunction

    // Left or top margin that centers the scaled image on one axis
    function automatic logic [COORD_W-1:0] center_pad(input logic [REG_W-1:0] s,
                                                      input logic [REG_W-1:0] d);
        logic [39:0] fit;
        fit = (40'(s) * frame_scale + ROUND_HALF) >> SCALE_FRAC_BITS;
        if (fit > 40'(d)) fit = 40'(d);
        return COORD_W'((40'(d) - fit) / 2);
    endfunction

    // Recompute scale and margins at the top of a frame
    function automatic void start_frame();
        logic [REG_W-1:0]     sw;
        logic [REG_W-1:0]     sh;
        logic [REG_W-1:0]     dw;
        logic [REG_W-1:0]     dh;
        logic [DIV_NUM_W-1:0] fit_x;
        logic [DIV_NUM_W-1:0] fit_y;
        logic [DIV_NUM_W-1:0] fit;
        sw = usable_dim(geom_regs[CFG_SRC_WIDTH]);
        sh = usable_dim(geom_regs[CFG_SRC_HEIGHT]);
        dw = usable_dim(geom_regs[CFG_DST_WIDTH]);
        dh = usable_dim(geom_regs[CFG_DST_HEIGHT]);
        fit_x = (DIV_NUM_W'(dw) << SCALE_FRAC_BITS) / sw;
        fit_y = (DIV_NUM_W'(dh) << SCALE_FRAC_BITS) / sh;
        fit = (fit_x < fit_y) ? fit_x : fit_y;
        if (fit > SCALE_CAP) fit = SCALE_CAP;
        frame_scale = SCALE_W'(fit);
        pad_x = center_pad(sw, dw);
        pad_y = center_pad(sh, dh);
        frame_valid = 1'b1;
        frames_started++;
    endfunction

    // Destination span of one source column or row, end exclusive, never empty
    function automatic void cover_span(input logic [REG_W-1:0] pos,
                                       input logic [COORD_W-1:0] pad,
                                       output logic [39:0] lo, output logic [39:0] hi);
        lo = 40'(pad) + ((40'(pos) * frame_scale) >> SCALE_FRAC_BITS);
        hi = 40'(pad) + (((40'(pos) + 40'd1) * frame_scale) >> SCALE_FRAC_BITS);
        if (hi <= lo) hi = lo + 40'd1;
    endfunction

    // Queue the writes one source pixel paints, then step the raster
    function automatic void paint_pixel(input logic [WORD_W-1:0] word);
        logic [REG_W-1:0] sw;
        logic [REG_W-1:0] sh;
        logic [39:0]      x0;
        logic [39:0]      x1;
        logic [39:0]      y0;
        logic [39:0]      y1;
        int               n;
        if (!frame_valid) start_frame();
        sw = usable_dim(geom_regs[CFG_SRC_WIDTH]);
        sh = usable_dim(geom_regs[CFG_SRC_HEIGHT]);
        cover_span(raster_col, pad_x, x0, x1);
        cover_span(raster_row, pad_y, y0, y1);
        if (x1 > 40'(usable_dim(geom_regs[CFG_DST_WIDTH]))) begin
            x1 = 40'(usable_dim(geom_regs[CFG_DST_WIDTH]));
        end
        if (y1 > 40'(usable_dim(geom_regs[CFG_DST_HEIGHT]))) begin
            y1 = 40'(usable_dim(geom_regs[CFG_DST_HEIGHT]));
        end
        n = 0;
        for (logic [39:0] y = y0; y < y1; y++) begin
            for (logic [39:0] x = x0; x < x1; x++) begin
                if (n < MAX_WRITES) begin
                    writes_due.push_back('{dst_x: COORD_W'(x), dst_y: COORD_W'(y),
                                           pixel_word: word, last_write: 1'b0});
                    n++;
                end
            end
        end
        if (n > 0) writes_due[writes_due.size() - 1].last_write = 1'b1;
        raster_col++;
        if (raster_col >= sw) begin
            raster_col = '0;
            raster_row++;
            if (raster_row >= sh) begin
                raster_row = '0;
                frame_valid = 1'b0;
            end
        end
    endfunction

    // A register write restarts the frame at the origin
    function automatic void store_reg(input t_cfg_idx idx, input logic [REG_W-1:0] value);
        geom_regs[idx] = value;
        raster_col = '0;
        raster_row = '0;
        frame_valid = 1'b0;
    endfunction

    function automatic void note_mismatch(input string field, input logic [31:0] want,
                                          input logic [31:0] got);
        if (mismatches < REPORT_LIMIT) begin
            $display("%0t: %s expected %0h, actual %0h", $time, field, want, got);
        end
        mismatches++;
    endfunction

    // Compare one accepted write with the oldest pending one
    function automatic void check_write(input t_out_item got);
        t_out_item want;
        if (writes_due.size() == 0) begin
            note_mismatch("write with none pending, pixel_word", '0, 32'(got.pixel_word));
            return;
        end
        want = writes_due.pop_front();
        writes_checked++;
        if (got.dst_x !== want.dst_x) begin
            note_mismatch("dst_x", 32'(want.dst_x), 32'(got.dst_x));
        end
        if (got.dst_y !== want.dst_y) begin
            note_mismatch("dst_y", 32'(want.dst_y), 32'(got.dst_y));
        end
        if (got.pixel_word !== want.pixel_word) begin
            note_mismatch("pixel_word", 32'(want.pixel_word), 32'(got.pixel_word));
        end
        if (got.last_write !== want.last_write) begin
            note_mismatch("last_write", 32'(want.last_write), 32'(got.last_write));
        end
    endfunction

    function automatic logic signed [COLOR_W-1:0] random_component();
        case ($urandom_range(0, 3))
            0: begin
                return COLOR_W'($urandom);
            end
            1: begin
                return COLOR_W'($urandom_range(0, COLOR_MAX_Q));
            end
            2: begin
                return COLOR_W'($urandom_range(COLOR_MAX_Q - 24, COLOR_MAX_Q + 24));
            end
            default: begin
                return -COLOR_W'($urandom_range(1, 64));
            end
        endcase
    endfunction

    // Mostly small sizes, now and then zero or beyond MAX_DIM
    function automatic logic [REG_W-1:0] random_dim(input int top);
        case ($urandom_range(0, 7))
            0: begin
                return '0;
            end
            1: begin
                return REG_W'($urandom_range(MAX_DIM + 1, (1 << REG_W) - 1));
            end
            default: begin
                return REG_W'($urandom_range(1, top));
            end
        endcase
    endfunction

    // Offer one pixel, wait for the transaction, then predict its writes
    task automatic send_pixel(input t_in_item px, input logic [WORD_W-1:0] word,
                              input bit gappy);
        int gap;
        bit taken;
        gap = (gappy && $urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= px;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = !o_in_stall;
            @(posedge i_clk);
        end
        paint_pixel(word);
        pixels_sent++;
    endtask

    // Drain every pending write and let frame setup finish
    task automatic settle();
        i_in_valid <= 1'b0;
        while (writes_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_geometry(input logic [REG_W-1:0] sw, input logic [REG_W-1:0] sh,
                                 input logic [REG_W-1:0] dw, input logic [REG_W-1:0] dh);
        t_cfg_idx         order [4] = '{CFG_SRC_WIDTH, CFG_SRC_HEIGHT,
                                        CFG_DST_WIDTH, CFG_DST_HEIGHT};
        logic [REG_W-1:0] vals [4];
        vals = '{sw, sh, dw, dh};
        settle();
        for (int r = 0; r < 4; r++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= order[r];
            i_cfg_data  <= vals[r];
            @(posedge i_clk);
            store_reg(order[r], vals[r]);
        end
        i_cfg_we <= 1'b0;
        settings_loaded++;
    endtask

    // One geometry, then a run of random pixels
    task automatic run_phase(input logic [REG_W-1:0] sw, input logic [REG_W-1:0] sh,
                             input logic [REG_W-1:0] dw, input logic [REG_W-1:0] dh,
                             input int n_items);
        t_in_item px;
        bit       gappy;
        load_geometry(sw, sh, dw, dh);
        gappy = !calm && $urandom_range(0, 2) != 0;
        for (int k = 0; k < n_items; k++) begin
            hold_window = n_items >= 100 && k >= 20 && k < 100;
            px = '{red_in: random_component(), green_in: random_component(),
                   blue_in: random_component()};
            send_pixel(px, pack_color(px), gappy);
        end
        hold_window = 1'b0;
    endtask

    // Receiver: stall in bursts, one long hold-off, check every transaction
    initial begin
        bit stall_next;
        bit rx_quiet;
        bit hold_done;
        int hold_left;
        int burst_left;
        int mode_left;
        stall_next = 1'b0;
        rx_quiet   = 1'b0;
        hold_done  = 1'b0;
        hold_left  = 0;
        burst_left = 0;
        mode_left  = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            i_out_stall <= stall_next;
            @(negedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) check_write(o_out_data);
            // plan the stall for the next edge
            if (mode_left == 0) begin
                rx_quiet  = $urandom_range(0, 1);
                mode_left = $urandom_range(40, 160);
            end
            mode_left--;
            if (!hold_done && hold_window) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                stall_next = 1'b1;
                hold_left--;
            end else if (burst_left > 0) begin
                stall_next = 1'b1;
                burst_left--;
            end else if (!calm && !rx_quiet && $urandom_range(0, 3) == 0) begin
                stall_next = 1'b1;
                burst_left = $urandom_range(0, 4);
            end else begin
                stall_next = 1'b0;
            end
        end
    end

    // Stimulus: reset, directed pixels, then a series of geometries
    initial begin
        t_swatch  swatch_rows [14];
        t_in_item px;
        swatch_rows = '{
            '{16'h0000, 16'h0000, 16'h0000, 1'b1, 24'h000000},
            '{16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1, 24'hFFFFFF},
            '{16'h8000, 16'h8000, 16'h8000, 1'b1, 24'h000000},
            '{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 24'h000000},
            '{16'h0FF0, 16'h0FF0, 16'h0FF0, 1'b1, 24'hFFFFFF},
            '{16'h0FF1, 16'h1000, 16'h0FEF, 1'b1, 24'hFFFFFE},
            '{16'h0010, 16'h000F, 16'h0001, 1'b1, 24'h010000},
            '{16'h0800, 16'h0100, 16'h1000, 1'b1, 24'h8010FF},
            '{16'h8000, 16'h7FFF, 16'h0000, 1'b1, 24'h00FF00},
            '{16'h5555, 16'hAAAA, 16'h0FF0, 1'b1, 24'hFF00FF},
            '{16'h0123, 16'h0456, 16'h0789, 1'b0, 24'h000000},
            '{16'h0A5A, 16'h0FF8, 16'h0007, 1'b0, 24'h000000},
            '{16'h7FF0, 16'h0001, 16'h8001, 1'b0, 24'h000000},
            '{16'h1234, 16'h0C3C, 16'hFFF0, 1'b0, 24'h000000}
        };

        // predictor state after reset
        geom_regs[CFG_SRC_WIDTH]  = RST_SRC_WIDTH;
        geom_regs[CFG_SRC_HEIGHT] = RST_SRC_HEIGHT;
        geom_regs[CFG_DST_WIDTH]  = RST_DST_WIDTH;
        geom_regs[CFG_DST_HEIGHT] = RST_DST_HEIGHT;
        frame_scale     = '0;
        frame_valid     = 1'b0;
        pad_x           = '0;
        pad_y           = '0;
        raster_col      = '0;
        raster_row      = '0;
        calm            = 1'b0;
        hold_window     = 1'b0;
        mismatches      = 0;
        writes_checked  = 0;
        pixels_sent     = 0;
        frames_started  = 0;
        settings_loaded = 0;

        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= CFG_SRC_WIDTH;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed pixels under the reset geometry, a 2x upscale
        foreach (swatch_rows[i]) begin
            px = '{red_in: swatch_rows[i].red, green_in: swatch_rows[i].green,
                   blue_in: swatch_rows[i].blue};
            send_pixel(px, swatch_rows[i].typed ? swatch_rows[i].word : pack_color(px),
                       1'b1);
        end

        // fixed geometries: extremes, out-of-range values, scale cap, odd ratios
        run_phase(13'd0,    13'd0,    13'd8191, 13'd8191, 6);
        run_phase(13'd8191, 13'd3,    13'd5,    13'd0,    20);
        run_phase(13'd4096, 13'd4096, 13'd1,    13'd1,    10);
        run_phase(13'd1,    13'd1,    13'd1,    13'd1,    8);
        run_phase(13'd3,    13'd5,    13'd10,   13'd7,    30);
        run_phase(13'd16,   13'd12,   13'd48,   13'd40,   150);
        run_phase(13'd7,    13'd2,    13'd4096, 13'd13,   28);
        run_phase(13'd1,    13'd4096, 13'd4096, 13'd4096, 20);
        run_phase(13'd4096, 13'd4096, 13'd4096, 13'd4096, 12);

        // random geometries, small frames so that frames wrap often
        for (int p = 0; p < 8; p++) begin
            if (p == 7) calm = 1'b1;
            run_phase(random_dim(9), random_dim(9), random_dim(40), random_dim(40),
                      $urandom_range(12, 30));
        end

        settle();
        $display("covered %0d source pixels over %0d geometries and %0d frame setups",
                 pixels_sent, settings_loaded + 1, frames_started);
        $display("checked %0d destination writes, %0d mismatches",
                 writes_checked, mismatches);
        if (mismatches == 0) begin
            $display("letterbox_nearest_upscaler_test: clean");
        end else begin
            $display("letterbox_nearest_upscaler_test: errors");
        end
        $finish;
    end

endmodule
